FILE: hdl/ata_chs_read_sequencer_assert.svh
// ----------------------------------------------------------------------------
// ata_chs_read_sequencer_assert.svh
// assertion macros for the checker file of the read sequencer
// ----------------------------------------------------------------------------
`ifndef ATA_CHS_READ_SEQUENCER_ASSERT_SVH
`define ATA_CHS_READ_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ACRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acrs check failed");

// next-cycle implication, disabled while reset is low
`define ACRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acrs check failed");

`endif

FILE: hdl/acrs_pkg.sv
// ----------------------------------------------------------------------------
// acrs_pkg
// types, widths and codes shared by the ata chs read sequencer modules
// ----------------------------------------------------------------------------
package acrs_pkg;

    // address and count widths of the internal state
    localparam int LBA_BITS   = 28;
    localparam int COUNT_BITS = 16;

    // field and register widths
    localparam int START_W    = 28;
    localparam int SCOUNT_W   = 16;
    localparam int STATUS_W   = 8;
    localparam int SPT_W      = 8;
    localparam int HEADS_W    = 5;
    localparam int MULTI_W    = 8;
    localparam int SIZE_W     = 28;
    localparam int SELECT_W   = 8;
    localparam int BYTE_W     = 8;
    localparam int CYL_W      = 16;
    localparam int REMAIN_W   = 16;
    localparam int ECC_W      = 16;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    // derived widths
    localparam int LEFT_W     = SPT_W + HEADS_W;
    localparam int CLAMP_W    = (COUNT_BITS > LEFT_W) ? COUNT_BITS : LEFT_W;
    localparam int WIDE_W     = (LBA_BITS > COUNT_BITS) ? LBA_BITS : COUNT_BITS;
    localparam int SUM_W      = ((WIDE_W > SIZE_W) ? WIDE_W : SIZE_W) + 1;
    localparam int DIV_CNT_W  = $clog2(LBA_BITS + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT = 3'd4;

    // configuration reset values
    localparam logic [SPT_W-1:0]    RST_SPT    = 8'd63;
    localparam logic [HEADS_W-1:0]  RST_HEADS  = 5'd16;
    localparam logic [MULTI_W-1:0]  RST_MULTI  = 8'd0;
    localparam logic [SIZE_W-1:0]   RST_SIZE   = 28'd0;
    localparam logic [SELECT_W-1:0] RST_SELECT = 8'hA0;

    // input opcodes and status bits
    localparam logic OP_REQUEST   = 1'b0;
    localparam int   STS_ERR_BIT  = 0;
    localparam int   STS_ECC_BIT  = 2;

    // task file command codes and the segment clamp
    localparam logic [BYTE_W-1:0] CMD_READ_SECTORS  = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_READ_MULTIPLE = 8'hC4;
    localparam logic [BYTE_W-1:0] BYTE_MAX          = 8'hFF;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CMD  = 3'd0,
        KIND_XFER = 3'd1,
        KIND_DONE = 3'd2,
        KIND_REJ  = 3'd3,
        KIND_ERR  = 3'd4,
        KIND_ECC  = 3'd5
    } t_kind;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT_REJ,
        S_EMIT_ERR,
        S_EMIT_ECC,
        S_EMIT_XFER,
        S_EMIT_DONE,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_LEFT,
        S_EMIT_CMD
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic  load_item;
        logic  req_accept;
        logic  ecc_bump;
        logic  xfer_update;
        logic  div_start;
        logic  div_sel_heads;
        logic  latch_div1;
        logic  latch_div2;
        logic  calc_left;
        logic  seg_load;
        logic  out_load;
        t_kind out_kind;
        logic  out_last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_req;
        logic reject;
        logic st_err;
        logic st_ecc;
        logic busy;
        logic div_done;
        logic req_zero;
        logic seg_zero;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hdl/acrs_div.sv
// ----------------------------------------------------------------------------
// acrs_div
// restoring divider, one quotient bit per cycle, 8-bit divisor
// ----------------------------------------------------------------------------
module acrs_div
    import acrs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [LBA_BITS-1:0] i_dividend,
    input  logic [BYTE_W-1:0]   i_divisor,
    output logic                o_done,
    output logic [LBA_BITS-1:0] o_quotient,
    output logic [BYTE_W-1:0]   o_remainder
);

    logic [LBA_BITS-1:0]  r_quot;
    logic [BYTE_W-1:0]    r_rem;
    logic [BYTE_W-1:0]    r_divisor;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [BYTE_W:0]      trial;
    logic                 fits;

    // partial remainder with the next dividend bit shifted in
    assign trial = {r_rem, r_quot[LBA_BITS-1]};
    assign fits  = (trial >= {1'b0, r_divisor});

    // step counter and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_CNT_W'(LBA_BITS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[LBA_BITS-2:0], fits};
            r_rem  <= fits ? BYTE_W'(trial - {1'b0, r_divisor}) : trial[BYTE_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quot;
    assign o_remainder = r_rem;

endmodule

FILE: hdl/acrs_dp.sv
// ----------------------------------------------------------------------------
// acrs_dp
// datapath: configuration, request state, chs split and result register
// ----------------------------------------------------------------------------
module acrs_dp
    import acrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_opcode,
    input  logic [START_W-1:0]    i_start_sector,
    input  logic [SCOUNT_W-1:0]   i_sector_count,
    input  logic [STATUS_W-1:0]   i_drive_status,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [KIND_W-1:0]     o_kind,
    output logic [BYTE_W-1:0]     o_sector_number,
    output logic [CYL_W-1:0]      o_cylinder,
    output logic [SELECT_W-1:0]   o_select_byte,
    output logic [BYTE_W-1:0]     o_command_code,
    output logic [BYTE_W-1:0]     o_count,
    output logic [REMAIN_W-1:0]   o_remaining,
    output logic [ECC_W-1:0]      o_ecc_warnings,
    output logic                  o_last
);

    // configuration registers
    logic [SPT_W-1:0]      r_spt;
    logic [HEADS_W-1:0]    r_heads;
    logic [MULTI_W-1:0]    r_multi;
    logic [SIZE_W-1:0]     r_size;
    logic [SELECT_W-1:0]   r_select;

    // latched input word
    logic                  r_op;
    logic [START_W-1:0]    r_start;
    logic [SCOUNT_W-1:0]   r_count_in;
    logic [STATUS_W-1:0]   r_status;

    // request state
    logic                  r_busy;
    logic [LBA_BITS-1:0]   r_next_sector;
    logic [COUNT_BITS-1:0] r_request_left;
    logic [BYTE_W-1:0]     r_segment_left;
    logic [ECC_W-1:0]      r_ecc_counter;

    // chs split and segment work values
    logic [BYTE_W-1:0]     r_sect_rem;
    logic [LBA_BITS-1:0]   r_track;
    logic [HEADS_W-1:0]    r_head;
    logic [CYL_W-1:0]      r_cyl;
    logic [LEFT_W-1:0]     r_left;
    logic [BYTE_W-1:0]     r_xfer_n;

    // result register
    logic                  r_out_valid;
    t_kind                 r_kind;
    logic [BYTE_W-1:0]     r_sector_number;
    logic [CYL_W-1:0]      r_cylinder;
    logic [SELECT_W-1:0]   r_select_byte;
    logic [BYTE_W-1:0]     r_command_code;
    logic [BYTE_W-1:0]     r_count;
    logic [REMAIN_W-1:0]   r_remaining;
    logic [ECC_W-1:0]      r_ecc_warnings;
    logic                  r_last;

    logic [SPT_W-1:0]      spt_eff;
    logic [HEADS_W-1:0]    heads_eff;
    logic [LBA_BITS-1:0]   start_m;
    logic [COUNT_BITS-1:0] count_m;
    logic [SUM_W-1:0]      end_sum;
    logic                  reject;

    logic [BYTE_W-1:0]     step0;
    logic [BYTE_W-1:0]     step1;
    logic [BYTE_W-1:0]     xfer_n;
    logic [COUNT_BITS-1:0] req_after;

    logic [HEADS_W-1:0]    heads_rest;
    logic [CLAMP_W-1:0]    req_x;
    logic [CLAMP_W-1:0]    left_x;
    logic [CLAMP_W-1:0]    clamp1;
    logic [BYTE_W-1:0]     seg_n;

    logic                  div_done;
    logic [LBA_BITS-1:0]   div_quot;
    logic [BYTE_W-1:0]     div_rem;
    logic [LBA_BITS-1:0]   div_dividend;
    logic [BYTE_W-1:0]     div_divisor;

    // zero geometry counts as one
    assign spt_eff   = (r_spt == '0) ? SPT_W'(1) : r_spt;
    assign heads_eff = (r_heads == '0) ? HEADS_W'(1) : r_heads;

    // request checks against busy, count and disk size
    assign start_m = LBA_BITS'(r_start);
    assign count_m = COUNT_BITS'(r_count_in);
    assign end_sum = SUM_W'(start_m) + SUM_W'(count_m);
    assign reject  = r_busy || (count_m == '0) ||
                     (SUM_W'(start_m) > SUM_W'(r_size)) || (end_sum > SUM_W'(r_size));

    // sectors moved by one interrupt
    assign step0     = (r_multi != '0) ? r_multi : BYTE_W'(1);
    assign step1     = (step0 > r_segment_left) ? r_segment_left : step0;
    assign xfer_n    = (COUNT_BITS'(step1) > r_request_left) ? r_request_left[BYTE_W-1:0]
                                                             : step1;
    assign req_after = r_request_left - COUNT_BITS'(xfer_n);

    // segment count clamped to cylinder end and to one byte
    assign heads_rest = heads_eff - r_head;
    assign req_x      = CLAMP_W'(r_request_left);
    assign left_x     = CLAMP_W'(r_left);
    assign clamp1     = (req_x > left_x) ? left_x : req_x;
    assign seg_n      = (clamp1 > CLAMP_W'(BYTE_MAX)) ? BYTE_MAX : clamp1[BYTE_W-1:0];

    // divider operands: sector by track size, then track by heads
    assign div_dividend = i_cmd.div_sel_heads ? r_track : r_next_sector;
    assign div_divisor  = i_cmd.div_sel_heads ? BYTE_W'(heads_eff) : spt_eff;

    acrs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt    <= RST_SPT;
            r_heads  <= RST_HEADS;
            r_multi  <= RST_MULTI;
            r_size   <= RST_SIZE;
            r_select <= RST_SELECT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SPT:    r_spt    <= i_cfg_wdata[SPT_W-1:0];
                CFG_HEADS:  r_heads  <= i_cfg_wdata[HEADS_W-1:0];
                CFG_MULTI:  r_multi  <= i_cfg_wdata[MULTI_W-1:0];
                CFG_SIZE:   r_size   <= i_cfg_wdata[SIZE_W-1:0];
                CFG_SELECT: r_select <= i_cfg_wdata[SELECT_W-1:0];
                default: ;
            endcase
        end
    end

    // input word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op       <= i_opcode;
            r_start    <= i_start_sector;
            r_count_in <= i_sector_count;
            r_status   <= i_drive_status;
        end
    end

    // request state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_next_sector  <= '0;
            r_request_left <= '0;
            r_segment_left <= '0;
            r_ecc_counter  <= '0;
        end else begin
            if (i_cmd.req_accept) begin
                r_busy         <= 1'b1;
                r_next_sector  <= start_m;
                r_request_left <= count_m;
            end
            if (i_cmd.ecc_bump && (r_ecc_counter != '1)) begin
                r_ecc_counter <= r_ecc_counter + 1'b1;
            end
            if (i_cmd.xfer_update) begin
                r_next_sector  <= LBA_BITS'(r_next_sector + LBA_BITS'(xfer_n));
                r_request_left <= req_after;
                if (req_after == '0) begin
                    r_busy         <= 1'b0;
                    r_segment_left <= '0;
                end else begin
                    r_segment_left <= r_segment_left - xfer_n;
                end
            end
            if (i_cmd.seg_load) begin
                r_segment_left <= seg_n;
            end
        end
    end

    // chs split and segment work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.xfer_update) begin
            r_xfer_n <= xfer_n;
        end
        if (i_cmd.latch_div1) begin
            r_sect_rem <= div_rem;
            r_track    <= div_quot;
        end
        if (i_cmd.latch_div2) begin
            r_head <= div_rem[HEADS_W-1:0];
            r_cyl  <= CYL_W'(div_quot);
        end
        if (i_cmd.calc_left) begin
            r_left <= LEFT_W'(LEFT_W'(spt_eff) * LEFT_W'(heads_rest)) - LEFT_W'(r_sect_rem);
        end
    end

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind          <= i_cmd.out_kind;
            r_remaining     <= REMAIN_W'(r_request_left);
            r_ecc_warnings  <= r_ecc_counter;
            r_last          <= i_cmd.out_last;
            r_sector_number <= '0;
            r_cylinder      <= '0;
            r_select_byte   <= '0;
            r_command_code  <= '0;
            r_count         <= '0;
            case (i_cmd.out_kind)
                KIND_CMD: begin
                    r_sector_number <= BYTE_W'({1'b0, r_sect_rem} + 9'd1);
                    r_cylinder      <= r_cyl;
                    r_select_byte   <= r_select | SELECT_W'(r_head);
                    r_command_code  <= (r_multi != '0) ? CMD_READ_MULTIPLE : CMD_READ_SECTORS;
                    r_count         <= seg_n;
                end
                KIND_XFER: begin
                    r_count <= r_xfer_n;
                end
                default: ;
            endcase
        end
    end

    // status to the controller
    always_comb begin
        o_stat.is_req   = (r_op == OP_REQUEST);
        o_stat.reject   = reject;
        o_stat.st_err   = r_status[STS_ERR_BIT];
        o_stat.st_ecc   = r_status[STS_ECC_BIT];
        o_stat.busy     = r_busy;
        o_stat.div_done = div_done;
        o_stat.req_zero = (r_request_left == '0);
        o_stat.seg_zero = (r_segment_left == '0);
        o_stat.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_sector_number = r_sector_number;
    assign o_cylinder      = r_cylinder;
    assign o_select_byte   = r_select_byte;
    assign o_command_code  = r_command_code;
    assign o_count         = r_count;
    assign o_remaining     = r_remaining;
    assign o_ecc_warnings  = r_ecc_warnings;
    assign o_last          = r_last;

endmodule

FILE: hdl/acrs_ctrl.sv
// ----------------------------------------------------------------------------
// acrs_ctrl
// controller: sequences decode, chs division and result emission
// ----------------------------------------------------------------------------
module acrs_ctrl
    import acrs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.is_req) begin
                    n_state = i_stat.reject ? S_EMIT_REJ : S_DIV1_GO;
                end else if (i_stat.st_err) begin
                    n_state = S_EMIT_ERR;
                end else if (i_stat.st_ecc) begin
                    n_state = S_EMIT_ECC;
                end else if (i_stat.busy) begin
                    n_state = S_EMIT_XFER;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_REJ, S_EMIT_ERR, S_EMIT_ECC, S_EMIT_DONE, S_EMIT_CMD: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_EMIT_XFER: begin
                if (i_stat.out_free) begin
                    if (i_stat.req_zero) begin
                        n_state = S_EMIT_DONE;
                    end else if (i_stat.seg_zero) begin
                        n_state = S_DIV1_GO;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV1_GO:   n_state = S_DIV1_WAIT;
            S_DIV1_WAIT: begin
                if (i_stat.div_done) n_state = S_DIV2_GO;
            end
            S_DIV2_GO:   n_state = S_DIV2_WAIT;
            S_DIV2_WAIT: begin
                if (i_stat.div_done) n_state = S_LEFT;
            end
            S_LEFT:      n_state = S_EMIT_CMD;
            default:     n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.out_kind = KIND_CMD;
        o_cmd.out_last = 1'b1;
        o_stall        = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_item = i_valid;
            end
            S_DECODE: begin
                if (i_stat.is_req) begin
                    o_cmd.req_accept = !i_stat.reject;
                end else if (!i_stat.st_err && i_stat.st_ecc) begin
                    o_cmd.ecc_bump = 1'b1;
                end else if (!i_stat.st_err && i_stat.busy) begin
                    o_cmd.xfer_update = 1'b1;
                end
            end
            S_EMIT_REJ: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_kind = KIND_REJ;
            end
            S_EMIT_ERR: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_kind = KIND_ERR;
            end
            S_EMIT_ECC: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_kind = KIND_ECC;
            end
            S_EMIT_XFER: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_kind = KIND_XFER;
                o_cmd.out_last = !(i_stat.req_zero || i_stat.seg_zero);
            end
            S_EMIT_DONE: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_kind = KIND_DONE;
            end
            S_DIV1_GO: begin
                o_cmd.div_start = 1'b1;
            end
            S_DIV1_WAIT: begin
                o_cmd.latch_div1 = i_stat.div_done;
            end
            S_DIV2_GO: begin
                o_cmd.div_start     = 1'b1;
                o_cmd.div_sel_heads = 1'b1;
            end
            S_DIV2_WAIT: begin
                o_cmd.div_sel_heads = 1'b1;
                o_cmd.latch_div2    = i_stat.div_done;
            end
            S_LEFT: begin
                o_cmd.calc_left = 1'b1;
            end
            S_EMIT_CMD: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.seg_load = i_stat.out_free;
                o_cmd.out_kind = KIND_CMD;
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/ata_chs_read_sequencer.sv
// ----------------------------------------------------------------------------
// ata_chs_read_sequencer
// host-side ata read sequencer for one chs drive: checks requests, splits
// the linear sector into cylinder, head and sector and issues task-file
// read commands; drive interrupts report errors, ecc warnings and transfers
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   opcode, start_sector, sector_count,
//                                           drive_status
//  result    out        o_valid / i_stall   kind .. last, one or two words
//  config    in         i_cfg_wr_en         i_cfg_index, i_cfg_wdata
//
//  one input word is worked on at a time; o_stall is low only while idle
//  interrupts without a new command give their results straight from the decode
//  state; a command result for an accepted request (or after a drained segment)
//  waits on the one-bit-per-cycle divider, run twice (by track size, then by
//  heads), and on the cylinder-end clamp
//  a result waiting under i_stall holds the sequencer in its emit state
//  synchronous active-low reset; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
module ata_chs_read_sequencer
    import acrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [START_W-1:0]    i_start_sector,
    input  logic [SCOUNT_W-1:0]   i_sector_count,
    input  logic [STATUS_W-1:0]   i_drive_status,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [KIND_W-1:0]     o_kind,
    output logic [BYTE_W-1:0]     o_sector_number,
    output logic [CYL_W-1:0]      o_cylinder,
    output logic [SELECT_W-1:0]   o_select_byte,
    output logic [BYTE_W-1:0]     o_command_code,
    output logic [BYTE_W-1:0]     o_count,
    output logic [REMAIN_W-1:0]   o_remaining,
    output logic [ECC_W-1:0]      o_ecc_warnings,
    output logic                  o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // controller
    acrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // datapath
    acrs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_opcode),
        .i_start_sector  (i_start_sector),
        .i_sector_count  (i_sector_count),
        .i_drive_status  (i_drive_status),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_sector_number (o_sector_number),
        .o_cylinder      (o_cylinder),
        .o_select_byte   (o_select_byte),
        .o_command_code  (o_command_code),
        .o_count         (o_count),
        .o_remaining     (o_remaining),
        .o_ecc_warnings  (o_ecc_warnings),
        .o_last          (o_last)
    );

endmodule

FILE: hdl/acrs_checker.sv
// ----------------------------------------------------------------------------
// acrs_checker
// port-level checks of the read sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "ata_chs_read_sequencer_assert.svh"

module acrs_checker
    import acrs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  i_opcode,
    input logic [START_W-1:0]    i_start_sector,
    input logic [SCOUNT_W-1:0]   i_sector_count,
    input logic [STATUS_W-1:0]   i_drive_status,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [KIND_W-1:0]     o_kind,
    input logic [BYTE_W-1:0]     o_sector_number,
    input logic [CYL_W-1:0]      o_cylinder,
    input logic [SELECT_W-1:0]   o_select_byte,
    input logic [BYTE_W-1:0]     o_command_code,
    input logic [BYTE_W-1:0]     o_count,
    input logic [REMAIN_W-1:0]   o_remaining,
    input logic [ECC_W-1:0]      o_ecc_warnings,
    input logic                  o_last
);

    // a stalled result word holds
    `ACRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kind) && $stable(o_count) && $stable(o_remaining))

    // one word at a time: an accepted input word closes the input side
    `ACRS_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // a finished request has nothing left and ends its input word
    `ACRS_ASSERT_NOW(a_done_empty, i_clk, i_rst_n, o_valid && (o_kind == KIND_DONE), (o_remaining == '0) && o_last)

    // an issued command always moves sectors from a one-based sector
    `ACRS_ASSERT_NOW(a_cmd_sane, i_clk, i_rst_n, o_valid && (o_kind == KIND_CMD), (o_count != '0) && (o_sector_number != '0) && o_last)

endmodule

bind ata_chs_read_sequencer acrs_checker u_acrs_checker (.*);

FILE: tb/tb_ata_chs_read_sequencer.sv
// ----------------------------------------------------------------------------
// tb_ata_chs_read_sequencer
// self-checking bench for the ata chs read sequencer: a queue-fed driver
// sends request and interrupt words, a monitor checks every result word
// against a cycle-free predictor of the sequencer, over several geometries
// ----------------------------------------------------------------------------
module tb_ata_chs_read_sequencer;
    import acrs_pkg::*;

    localparam logic        OP_INTERRUPT = 1'b1;
    localparam int unsigned DRAIN_CYCLES = 2 * (LBA_BITS + 2) + 40;
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned PRINT_CAP    = 25;
    localparam int unsigned LBA_TOP      = 28'hFFFFFFF;
    localparam int unsigned ECC_BURST    = 10;
    localparam int unsigned BIG_COUNT    = 65535;

    typedef enum int {IRQ_PLAIN, IRQ_ERROR, IRQ_ECC} t_irq_flavor;

    typedef struct {
        logic                opcode;
        logic [START_W-1:0]  start_sector;
        logic [SCOUNT_W-1:0] sector_count;
        logic [STATUS_W-1:0] drive_status;
    } t_host_word;

    typedef struct {
        t_kind               kind;
        logic [BYTE_W-1:0]   sector_number;
        logic [CYL_W-1:0]    cylinder;
        logic [SELECT_W-1:0] select_byte;
        logic [BYTE_W-1:0]   command_code;
        logic [BYTE_W-1:0]   count;
        logic [REMAIN_W-1:0] remaining;
        logic [ECC_W-1:0]    ecc_warnings;
        logic                last;
    } t_result_word;

    // dut ports, all inputs known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_SPT;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_opcode = OP_REQUEST;
    logic [START_W-1:0]    i_start_sector = '0;
    logic [SCOUNT_W-1:0]   i_sector_count = '0;
    logic [STATUS_W-1:0]   i_drive_status = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [KIND_W-1:0]     o_kind;
    logic [BYTE_W-1:0]     o_sector_number;
    logic [CYL_W-1:0]      o_cylinder;
    logic [SELECT_W-1:0]   o_select_byte;
    logic [BYTE_W-1:0]     o_command_code;
    logic [BYTE_W-1:0]     o_count;
    logic [REMAIN_W-1:0]   o_remaining;
    logic [ECC_W-1:0]      o_ecc_warnings;
    logic                  o_last;

    // geometry registers as the sequencer holds them
    logic [SPT_W-1:0]      geo_spt    = RST_SPT;
    logic [HEADS_W-1:0]    geo_heads  = RST_HEADS;
    logic [MULTI_W-1:0]    geo_multi  = RST_MULTI;
    logic [SIZE_W-1:0]     geo_size   = RST_SIZE;
    logic [SELECT_W-1:0]   geo_select = RST_SELECT;

    // read progress as the sequencer holds it
    logic                  rd_busy = 1'b0;
    logic [LBA_BITS-1:0]   rd_next_sector = '0;
    logic [COUNT_BITS-1:0] rd_left = '0;
    logic [BYTE_W-1:0]     rd_seg_left = '0;
    logic [ECC_W-1:0]      rd_ecc = '0;

    t_host_word            host_words[$];
    t_result_word          read_results_due[$];
    t_host_word            next_word;
    t_result_word          want;

    bit                    word_taken = 1'b0;
    bit                    idling_on = 1'b1;
    int unsigned           gap_left = 0;
    int unsigned           stall_left = 0;
    int unsigned           cycle_count = 0;
    int unsigned           mismatch_count = 0;
    int unsigned           words_queued = 0;
    int unsigned           words_accepted = 0;
    int unsigned           results_seen = 0;
    int unsigned           settings_used = 0;
    int unsigned           kind_seen[0:7];

    ata_chs_read_sequencer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_start_sector  (i_start_sector),
        .i_sector_count  (i_sector_count),
        .i_drive_status  (i_drive_status),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_sector_number (o_sector_number),
        .o_cylinder      (o_cylinder),
        .o_select_byte   (o_select_byte),
        .o_command_code  (o_command_code),
        .o_count         (o_count),
        .o_remaining     (o_remaining),
        .o_ecc_warnings  (o_ecc_warnings),
        .o_last          (o_last)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, read_results_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // result word with the current remaining and ecc counts
    function automatic void post_result(input t_kind k, input int unsigned sec,
                                        input int unsigned cyl, input int unsigned sel,
                                        input int unsigned cmd, input int unsigned cnt,
                                        input logic last);
        t_result_word w;
        w.kind          = k;
        w.sector_number = sec[BYTE_W-1:0];
        w.cylinder      = cyl[CYL_W-1:0];
        w.select_byte   = sel[SELECT_W-1:0];
        w.command_code  = cmd[BYTE_W-1:0];
        w.count         = cnt[BYTE_W-1:0];
        w.remaining     = rd_left;
        w.ecc_warnings  = rd_ecc;
        w.last          = last;
        read_results_due.push_back(w);
    endfunction

    // split next sector into chs and open a segment clamped to the cylinder
    function automatic void issue_segment();
        int unsigned spt, heads, track, sect, head, cyl, left, n;
        spt   = (geo_spt == 0) ? 1 : geo_spt;
        heads = (geo_heads == 0) ? 1 : geo_heads;
        track = rd_next_sector / spt;
        sect  = rd_next_sector % spt + 1;
        head  = track % heads;
        cyl   = track / heads;
        left  = spt * heads - head * spt - (sect - 1);
        n     = rd_left;
        if (n > left)
            n = left;
        if (n > BYTE_MAX)
            n = BYTE_MAX;
        rd_seg_left = n[BYTE_W-1:0];
        post_result(KIND_CMD, sect, cyl, geo_select | head,
                    (geo_multi != 0) ? CMD_READ_MULTIPLE : CMD_READ_SECTORS, n, 1'b1);
    endfunction

    // results caused by one accepted host word
    function automatic void compute_read_results(input logic op,
                                                 input logic [START_W-1:0] start,
                                                 input logic [SCOUNT_W-1:0] cnt,
                                                 input logic [STATUS_W-1:0] status);
        int unsigned s, c, sz, n;
        s  = start;
        c  = cnt;
        sz = geo_size;
        if (op == OP_REQUEST) begin
            if (rd_busy || c == 0 || s > sz || s + c > sz) begin
                post_result(KIND_REJ, 0, 0, 0, 0, 0, 1'b1);
            end else begin
                rd_busy        = 1'b1;
                rd_next_sector = start;
                rd_left        = cnt;
                issue_segment();
            end
        end else if (status[STS_ERR_BIT]) begin
            post_result(KIND_ERR, 0, 0, 0, 0, 0, 1'b1);
        end else if (status[STS_ECC_BIT]) begin
            if (rd_ecc != '1)
                rd_ecc++;
            post_result(KIND_ECC, 0, 0, 0, 0, 0, 1'b1);
        end else if (rd_busy) begin
            n = (geo_multi != 0) ? geo_multi : 1;
            if (n > rd_seg_left)
                n = rd_seg_left;
            if (n > rd_left)
                n = rd_left;
            rd_next_sector = rd_next_sector + n[LBA_BITS-1:0];
            rd_left        = rd_left - n[COUNT_BITS-1:0];
            rd_seg_left    = rd_seg_left - n[BYTE_W-1:0];
            if (rd_left == 0) begin
                rd_busy     = 1'b0;
                rd_seg_left = '0;
                post_result(KIND_XFER, 0, 0, 0, 0, n, 1'b0);
                post_result(KIND_DONE, 0, 0, 0, 0, 0, 1'b1);
            end else if (rd_seg_left == 0) begin
                post_result(KIND_XFER, 0, 0, 0, 0, n, 1'b0);
                issue_segment();
            end else begin
                post_result(KIND_XFER, 0, 0, 0, 0, n, 1'b1);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch on result word %0d, %s: got %0h, predicted %0h",
                     results_seen, what, got, exp_val);
    endtask

    // monitor: predict on each accepted host word, check each result word
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            compute_read_results(i_opcode, i_start_sector, i_sector_count, i_drive_status);
            words_accepted++;
            word_taken = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            kind_seen[o_kind]++;
            if (read_results_due.size() == 0) begin
                report_mismatch("word with none due, kind", o_kind, 0);
            end else begin
                want = read_results_due.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", o_kind, want.kind);
                if (o_sector_number !== want.sector_number)
                    report_mismatch("sector_number", o_sector_number, want.sector_number);
                if (o_cylinder !== want.cylinder)
                    report_mismatch("cylinder", o_cylinder, want.cylinder);
                if (o_select_byte !== want.select_byte)
                    report_mismatch("select_byte", o_select_byte, want.select_byte);
                if (o_command_code !== want.command_code)
                    report_mismatch("command_code", o_command_code, want.command_code);
                if (o_count !== want.count)
                    report_mismatch("count", o_count, want.count);
                if (o_remaining !== want.remaining)
                    report_mismatch("remaining", o_remaining, want.remaining);
                if (o_ecc_warnings !== want.ecc_warnings)
                    report_mismatch("ecc_warnings", o_ecc_warnings, want.ecc_warnings);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // driver: host words from the queue, random gaps and result stalls
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || word_taken) begin
                word_taken = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (host_words.size() > 0) begin
                    next_word = host_words.pop_front();
                    i_opcode       <= next_word.opcode;
                    i_start_sector <= next_word.start_sector;
                    i_sector_count <= next_word.sector_count;
                    i_drive_status <= next_word.drive_status;
                    i_valid        <= 1'b1;
                    if (idling_on && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 7);
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 6);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    function automatic void queue_word(input logic op, input int unsigned start,
                                       input int unsigned cnt, input int unsigned status);
        t_host_word w;
        w.opcode       = op;
        w.start_sector = start[START_W-1:0];
        w.sector_count = cnt[SCOUNT_W-1:0];
        w.drive_status = status[STATUS_W-1:0];
        host_words.push_back(w);
        words_queued++;
    endfunction

    // interrupt with random unused fields and status bits per flavor
    function automatic void queue_interrupt(input t_irq_flavor flavor);
        logic [STATUS_W-1:0] status;
        status = $urandom_range(0, 255);
        status[STS_ERR_BIT] = (flavor == IRQ_ERROR);
        if (flavor == IRQ_ECC)
            status[STS_ECC_BIT] = 1'b1;
        else if (flavor == IRQ_PLAIN)
            status[STS_ECC_BIT] = 1'b0;
        queue_word(OP_INTERRUPT, $urandom_range(0, LBA_TOP), $urandom_range(0, 65535),
                   status);
    endfunction

    // in-range request and enough interrupts to drain it, sometimes cut short
    function automatic void add_read_sequence(input int unsigned want_cnt);
        int unsigned cnt, start, per_irq, cyl_size, irq_total, k;
        cnt = want_cnt;
        if (cnt > geo_size)
            cnt = geo_size;
        if (cnt == 0) begin
            queue_word(OP_REQUEST, 0, 1, $urandom_range(0, 255));
        end else begin
            start = $urandom_range(0, geo_size - cnt);
            if ($urandom_range(0, 9) == 0)
                start = geo_size - cnt;
            queue_word(OP_REQUEST, start, cnt, $urandom_range(0, 255));
            per_irq   = (geo_multi != 0) ? geo_multi : 1;
            cyl_size  = ((geo_spt != 0) ? geo_spt : 1) * ((geo_heads != 0) ? geo_heads : 1);
            irq_total = cnt / per_irq + cnt / BYTE_MAX + cnt / cyl_size + 3;
            if (irq_total > cnt)
                irq_total = cnt;
            if ($urandom_range(0, 7) == 0)
                irq_total = $urandom_range(0, irq_total - 1);
            for (k = 0; k < irq_total; k++) begin
                if ($urandom_range(0, 15) == 0)
                    queue_interrupt($urandom_range(0, 1) ? IRQ_ERROR : IRQ_ECC);
                queue_interrupt(IRQ_PLAIN);
            end
        end
    endfunction

    // mostly whole reads, the rest bad requests and stray interrupts
    function automatic void fill_random_phase(input int unsigned target);
        int unsigned base, pick;
        base = words_queued;
        while (words_queued - base < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if (geo_multi >= 8 && $urandom_range(0, 7) == 0)
                    add_read_sequence($urandom_range(49, 400));
                else
                    add_read_sequence($urandom_range(1, 48));
            end else if (pick < 85) begin
                case ($urandom_range(0, 2))
                    0: queue_word(OP_REQUEST, $urandom_range(0, LBA_TOP), 0,
                                  $urandom_range(0, 255));
                    1: queue_word(OP_REQUEST, $urandom_range(0, LBA_TOP),
                                  $urandom_range(0, 65535), $urandom_range(0, 255));
                    default: queue_word(OP_REQUEST, geo_size, $urandom_range(1, 65535),
                                        $urandom_range(0, 255));
                endcase
            end else begin
                queue_word(OP_INTERRUPT, $urandom_range(0, LBA_TOP),
                           $urandom_range(0, 65535), $urandom_range(0, 255));
            end
        end
    endfunction

    // one write per cycle, upper data bits random
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned width,
                             input int unsigned value);
        logic [CFG_DATA_W-1:0] wdata;
        wdata = ($urandom << width) | value;
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= wdata;
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input int unsigned spt, input int unsigned heads,
                                input int unsigned multi, input int unsigned size,
                                input int unsigned sel);
        @(negedge i_clk);
        write_reg(CFG_SPT, SPT_W, spt);
        write_reg(CFG_HEADS, HEADS_W, heads);
        write_reg(CFG_MULTI, MULTI_W, multi);
        write_reg(CFG_SIZE, SIZE_W, size);
        write_reg(CFG_SELECT, SELECT_W, sel);
        i_cfg_wr_en <= 1'b0;
        geo_spt    = spt;
        geo_heads  = heads;
        geo_multi  = multi;
        geo_size   = size;
        geo_select = sel;
        settings_used++;
    endtask

    // all words sent, all results back, then let a silent item finish
    task automatic wait_quiet();
        do
            @(posedge i_clk);
        while (host_words.size() != 0 || i_valid || read_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned k;
        for (k = 0; k < 8; k++)
            kind_seen[k] = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry, empty disk: rejects, stray interrupt, ecc, error
        queue_word(OP_REQUEST, 0, 1, 0);
        queue_word(OP_INTERRUPT, 0, 0, 8'h00);
        queue_word(OP_INTERRUPT, 0, 0, 8'h04);
        queue_word(OP_INTERRUPT, 0, 0, 8'hFF);
        wait_quiet();

        // small geometry: bounds checks, busy reject, single-sector restarts
        set_geometry(4, 2, 0, 1000, 8'hE0);
        queue_word(OP_REQUEST, 0, 0, 0);
        queue_word(OP_REQUEST, 1001, 1, 0);
        queue_word(OP_REQUEST, 990, 11, 0);
        queue_word(OP_REQUEST, 995, 5, 0);
        queue_word(OP_REQUEST, 0, 1, 0);
        queue_word(OP_INTERRUPT, 0, 0, 8'h40);
        queue_word(OP_INTERRUPT, 0, 0, 8'h04);
        queue_word(OP_INTERRUPT, 0, 0, 8'h80);
        queue_word(OP_INTERRUPT, 0, 0, 8'h01);
        queue_word(OP_INTERRUPT, 0, 0, 8'h00);
        queue_word(OP_INTERRUPT, 0, 0, 8'hFA);
        queue_word(OP_INTERRUPT, 0, 0, 8'h00);
        queue_word(OP_REQUEST, 6, 4, 0);
        for (k = 0; k < 4; k++)
            queue_word(OP_INTERRUPT, 0, 0, 8'h40);
        wait_quiet();

        // zero geometry, full disk: top sector, wrapping cylinder, multi mode
        set_geometry(0, 0, 3, LBA_TOP, 8'hFF);
        queue_word(OP_REQUEST, LBA_TOP, 1, 0);
        queue_word(OP_REQUEST, LBA_TOP - 1, 1, 0);
        queue_word(OP_REQUEST, 0, 16'hFFFF, 0);
        queue_word(OP_INTERRUPT, 0, 0, 0);
        queue_word(OP_REQUEST, 70000, 3, 0);
        for (k = 0; k < 3; k++)
            queue_word(OP_INTERRUPT, 0, 0, 0);
        wait_quiet();

        // random reads over a spread of geometries
        set_geometry(63, 16, 0, 1 << 20, 8'hA0);
        fill_random_phase(20);
        wait_quiet();
        set_geometry(255, 31, 16, LBA_TOP, 8'hB0);
        fill_random_phase(20);
        wait_quiet();
        set_geometry(1, 1, 255, 5000, 8'h00);
        fill_random_phase(15);
        wait_quiet();
        set_geometry(17, 4, 8, LBA_TOP, $urandom_range(0, 255));
        fill_random_phase(15);
        wait_quiet();

        // largest request from sector zero, each interrupt drains a full segment
        set_geometry(255, 16, 255, LBA_TOP, 8'hE0);
        queue_word(OP_REQUEST, 0, BIG_COUNT, 0);
        for (k = 0; k < BIG_COUNT / BYTE_MAX; k++)
            queue_interrupt(IRQ_PLAIN);
        wait_quiet();

        for (k = 0; k < 2; k++) begin
            set_geometry($urandom_range(0, 255), $urandom_range(0, 31),
                         $urandom_range(0, 255),
                         $urandom_range(0, 1) ? $urandom_range(0, LBA_TOP)
                                              : $urandom_range(0, 3000),
                         $urandom_range(0, 255));
            fill_random_phase(10);
            wait_quiet();
        end

        // closing stretch without idling, a run of ecc interrupts at the end
        idling_on = 1'b0;
        set_geometry(7, 3, 0, 30000, 8'hA0);
        fill_random_phase(15);
        for (k = 0; k < ECC_BURST; k++)
            queue_interrupt(IRQ_ECC);
        wait_quiet();

        $display("covered %0d host words under %0d register settings, %0d result words",
                 words_accepted, settings_used, results_seen);
        $display("by kind: cmd %0d xfer %0d done %0d rej %0d err %0d ecc %0d, ecc count %0d",
                 kind_seen[KIND_CMD], kind_seen[KIND_XFER], kind_seen[KIND_DONE],
                 kind_seen[KIND_REJ], kind_seen[KIND_ERR], kind_seen[KIND_ECC], rd_ecc);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
